@@ rtl/core/rcss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rcss_pkg;

  localparam int WORD_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_COUNT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CANDIDATE_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_CATEGORY   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/rcss_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rcss_in_if #(
  parameter int RANDOM_BITS = 31
);
  logic                         valid;
  logic                         ready;
  logic signed [31:0]           cell_value;
  logic        [RANDOM_BITS-1:0] random_word;
  logic                         first_cell;

  modport source (output valid, output cell_value, output random_word, output first_cell,
                  input ready);
  modport sink   (input valid, input cell_value, input random_word, input first_cell,
                  output ready);
endinterface

interface rcss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic               selected;
  logic               all_targets_met;
  logic               count_error;

  modport source (output valid, output out_value, output selected, output all_targets_met,
                  output count_error, input ready);
  modport sink   (input valid, input out_value, input selected, input all_targets_met,
                  input count_error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rcss_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rcss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rcss_pkg::dp_status_t st,
  output rcss_pkg::dp_cmd_t        cmd
);

  rcss_pkg::state_t state_r;
  rcss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcss_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rcss_pkg::ST_SETUP;
      end
      rcss_pkg::ST_SETUP: begin
        state_nxt = st.bypass ? rcss_pkg::ST_FINISH : rcss_pkg::ST_DIVIDE;
      end
      rcss_pkg::ST_DIVIDE: begin
        if (st.div_last) state_nxt = rcss_pkg::ST_FINISH;
      end
      rcss_pkg::ST_FINISH: begin
        if (st.out_free) state_nxt = rcss_pkg::ST_IDLE;
      end
      default: state_nxt = rcss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      rcss_pkg::ST_IDLE: begin
        in_ready    = rst_n;
        cmd.capture = in_valid && rst_n;
      end
      rcss_pkg::ST_SETUP: begin
        cmd.div_start = !st.bypass;
      end
      rcss_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      rcss_pkg::ST_FINISH: begin
        cmd.finish = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_capture_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == rcss_pkg::ST_SETUP)
    else $error("capture did not lead to setup");
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("not ready after finish");
  a_step_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> cmd.div_step)
    else $error("divide did not follow start");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rcss_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rcss_dp #(
  parameter int COUNT_BITS  = 32,
  parameter int RANDOM_BITS = 31
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     cfg_we,
  input  wire logic [rcss_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  wire logic [rcss_pkg::WORD_BITS-1:0]           cfg_wdata,
  input  wire logic signed [rcss_pkg::WORD_BITS-1:0]    cell_value,
  input  wire logic [RANDOM_BITS-1:0]                   random_word,
  input  wire logic                                     first_cell,
  input  wire rcss_pkg::dp_cmd_t                        cmd,
  output rcss_pkg::dp_status_t                          st,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed [rcss_pkg::WORD_BITS-1:0]         out_value,
  output logic                                          selected,
  output logic                                          all_targets_met,
  output logic                                          count_error
);

  localparam int WB        = rcss_pkg::WORD_BITS;
  localparam int STEP_BITS = $clog2(RANDOM_BITS);

  logic [WB-1:0]          target_count_r;
  logic [WB-1:0]          candidate_count_r;
  logic signed [WB-1:0]   zero_category_r;

  logic [COUNT_BITS-1:0]  targets_r, targets_nxt;
  logic [COUNT_BITS-1:0]  cands_r, cands_nxt;

  logic signed [WB-1:0]   cell_r;
  logic [RANDOM_BITS-1:0] rnd_sh_r;
  logic [COUNT_BITS-1:0]  rem_r;
  logic [STEP_BITS-1:0]   step_r;

  logic                   out_valid_r;
  logic signed [WB-1:0]   out_value_r;
  logic                   selected_r;
  logic                   met_r;
  logic                   err_r;

  logic [COUNT_BITS+WB-1:0] tc_ext, cc_ext;
  logic [COUNT_BITS:0]      shifted;
  logic [COUNT_BITS:0]      diff;
  logic                     elig_w, err_w, bypass_w, sel_w;
  logic signed [WB-1:0]     value_w;

  assign tc_ext = {{COUNT_BITS{1'b0}}, target_count_r};
  assign cc_ext = {{COUNT_BITS{1'b0}}, candidate_count_r};

  assign elig_w   = (targets_r != '0) && !(zero_category_r == '0 && cell_r == '0);
  assign err_w    = elig_w && (cands_r == '0);
  assign bypass_w = !elig_w || (cands_r == '0);
  assign sel_w    = !bypass_w && (rem_r < targets_r);
  assign value_w  = !sel_w ? '0 : ((cell_r == '0) ? zero_category_r : cell_r);

  assign targets_nxt = sel_w ? targets_r - COUNT_BITS'(1) : targets_r;
  assign cands_nxt   = bypass_w ? cands_r : cands_r - COUNT_BITS'(1);

  assign shifted = {rem_r, rnd_sh_r[RANDOM_BITS-1]};
  assign diff    = shifted - {1'b0, cands_r};

  assign st.bypass   = bypass_w;
  assign st.div_last = (step_r == STEP_BITS'(RANDOM_BITS - 1));
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_count_r    <= '0;
      candidate_count_r <= '0;
      zero_category_r   <= '0;
      targets_r         <= '0;
      cands_r           <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rcss_pkg::CFG_TARGET_COUNT:    target_count_r    <= cfg_wdata;
          rcss_pkg::CFG_CANDIDATE_COUNT: candidate_count_r <= cfg_wdata;
          rcss_pkg::CFG_ZERO_CATEGORY:   zero_category_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.capture && first_cell) begin
        targets_r <= tc_ext[COUNT_BITS-1:0];
        cands_r   <= cc_ext[COUNT_BITS-1:0];
      end else if (cmd.finish) begin
        targets_r <= targets_nxt;
        cands_r   <= cands_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // restoring remainder, one random bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cell_r   <= cell_value;
      rnd_sh_r <= random_word;
    end
    if (cmd.div_start) begin
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= diff[COUNT_BITS] ? shifted[COUNT_BITS-1:0] : diff[COUNT_BITS-1:0];
      rnd_sh_r <= {rnd_sh_r[RANDOM_BITS-2:0], 1'b0};
      step_r   <= step_r + STEP_BITS'(1);
    end
    if (cmd.finish) begin
      out_value_r <= value_w;
      selected_r  <= sel_w;
      met_r       <= (targets_nxt == '0);
      err_r       <= err_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign selected        = selected_r;
  assign all_targets_met = met_r;
  assign count_error     = err_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < cands_r)
    else $error("remainder not below candidate count");
  a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> st.out_free)
    else $error("result overwritten before transfer");
  a_target_decrement: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && sel_w) |=> targets_r == $past(targets_r) - COUNT_BITS'(1))
    else $error("targets not decremented on selection");
  a_error_not_selected: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !(selected_r && err_r))
    else $error("error and selection together");
`endif

endmodule

`default_nettype wire

@@ rtl/core/raster_cell_selection_sampler.sv @@
// Flow: a skipped, exhausted or error cell goes from setup straight to finish;
//   a candidate cell first runs the bit-serial remainder over its random word.
// Input is accepted only when idle, so an item's result is registered before the next is taken.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, synchronous, active low) clears config registers, counters, state and valid.
`timescale 1ns / 1ps
`default_nettype none

module raster_cell_selection_sampler #(
  parameter int COUNT_BITS  = 32,
  parameter int RANDOM_BITS = 31
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rcss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [rcss_pkg::WORD_BITS-1:0]      cfg_wdata,
  rcss_in_if.sink                                  in_if,
  rcss_out_if.source                               out_if
);

  rcss_pkg::dp_cmd_t    cmd;
  rcss_pkg::dp_status_t st;
  logic                 in_ready;

  assign in_if.ready = in_ready;

  rcss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rcss_dp #(
    .COUNT_BITS  (COUNT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cell_value      (in_if.cell_value),
    .random_word     (in_if.random_word),
    .first_cell      (in_if.first_cell),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_value       (out_if.out_value),
    .selected        (out_if.selected),
    .all_targets_met (out_if.all_targets_met),
    .count_error     (out_if.count_error)
  );

endmodule

`default_nettype wire
